### design/weighted_urn_rarefaction_sampler_unit_defines.svh
// assertion macros for the weighted urn rarefaction sampler
// used by the top level only, no other dependencies
`ifndef WEIGHTED_URN_RAREFACTION_SAMPLER_UNIT_DEFINES_SVH
`define WEIGHTED_URN_RAREFACTION_SAMPLER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define WUR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("wur check failed");
`define WUR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("wur check failed");
`else
`define WUR_ASSERT(label, clk, rstn, prop)
`define WUR_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### design/wur_pkg.sv
// shared types, codes and constants of the weighted urn rarefaction sampler
// no dependencies
`timescale 1ns / 1ps
package wur_pkg;
    localparam int WUR_ENTRIES = 32;
    localparam logic [31:0] TARGET_RESET = 32'd1000;
    localparam logic [31:0] MIN_RESET = 32'd1;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_DRAW = 2'd2;

    localparam logic [1:0] KIND_ACK = 2'd0;
    localparam logic [1:0] KIND_DRAWN = 2'd1;
    localparam logic [1:0] KIND_KEPT = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_NO_RUN = 2'd2;

    localparam logic [1:0] CFG_TARGET = 2'd0;
    localparam logic [1:0] CFG_MIN = 2'd1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [4:0] entry_index;
        logic signed [31:0] feature_id;
        logic [31:0] abundance;
        logic [31:0] random_fraction;
    } in_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [4:0] drawn_index;
        logic signed [31:0] kept_feature;
        logic [31:0] kept_count;
        logic [31:0] draws_pending;
        logic [1:0] error_code;
        logic last;
    } out_t;

    typedef struct packed {
        logic [31:0] abund;
        logic [31:0] drawn;
        logic [31:0] feature;
    } cell_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_MUL, ST_ADD, ST_WALK, ST_DRAWN,
        ST_EVAL, ST_DECIDE, ST_KEEP, ST_FLUSH
    } state_t;

    function automatic out_t make_result(logic [1:0] kind, logic [4:0] idx,
                                         logic [31:0] feat, logic [31:0] cnt,
                                         logic [31:0] pend, logic [1:0] err);
        out_t r;
        r.result_kind = kind;
        r.drawn_index = idx;
        r.kept_feature = feat;
        r.kept_count = cnt;
        r.draws_pending = pend;
        r.error_code = err;
        r.last = 1'b0;
        return r;
    endfunction
endpackage

### design/wur_cell.sv
// one slot of the table ring: abundance, drawn count and feature id
// depends on wur_pkg
`timescale 1ns / 1ps
module wur_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  logic             clear_drawn,
    input  logic [31:0]      min_count,
    input  wur_pkg::cell_t   cell_in,
    output wur_pkg::cell_t   cell_out,
    output logic             qual
);
    logic [31:0] abund_reg, abund_next;
    logic [31:0] drawn_reg, drawn_next;
    logic [31:0] feature_reg, feature_next;

    always_comb begin
        abund_next = shift_en ? cell_in.abund : abund_reg;
        feature_next = shift_en ? cell_in.feature : feature_reg;
        drawn_next = clear_drawn ? 32'd0 : (shift_en ? cell_in.drawn : drawn_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            abund_reg <= '0;
            drawn_reg <= '0;
        end else begin
            abund_reg <= abund_next;
            drawn_reg <= drawn_next;
        end
    end

    always_ff @(posedge aclk) begin
        feature_reg <= feature_next;
    end

    // slot is kept when drawn at least min_count times
    assign qual = (drawn_reg >= min_count);
    assign cell_out = '{abund: abund_reg, drawn: drawn_reg, feature: feature_reg};
endmodule

### design/weighted_urn_rarefaction_sampler_unit.sv
// weighted urn rarefaction sampler: a ring of ENTRIES slot cells that shifts
// one slot a cycle past the head while walking, unless a kept slot stalls it; the
// controller reads and rewrites the head. a load walks the ring once; a draw
// multiplies, adds, walks, reports; a batch end evaluates the ring; output may stall
// one item is worked at a time; the ring walk sets the rate
// synchronous active-low reset clears slot counts, pool, run and control state
`timescale 1ns / 1ps
`include "weighted_urn_rarefaction_sampler_unit_defines.svh"
module weighted_urn_rarefaction_sampler_unit #(
    parameter int ENTRIES = wur_pkg::WUR_ENTRIES
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  wur_pkg::in_t   s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output wur_pkg::out_t  m_payload,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data
);
    localparam int CW = $clog2(ENTRIES);
    localparam int XW = CW + 5;

    // configuration registers
    logic [31:0] target_reg, min_reg;

    // control and run state
    wur_pkg::state_t state_reg, state_next;
    logic [CW-1:0] k_reg, k_next;
    logic [39:0]   pool_reg, pool_next;
    logic [31:0]   pending_reg, pending_next;
    logic          run_reg, run_next;
    wur_pkg::in_t  item_reg, item_next;

    // draw datapath
    logic [63:0]   prod_lo_reg, prod_lo_next;
    logic [39:0]   prod_hi_reg, prod_hi_next;
    logic [39:0]   pick_reg, pick_next;
    logic          found_reg, found_next;
    logic [CW-1:0] chosen_reg, chosen_next;
    logic [37:0]   total_reg, total_next;

    // one result held back so that last can be set on the final one
    wur_pkg::out_t hold_reg, hold_next;
    wur_pkg::out_t out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    // ring of cells
    wur_pkg::cell_t cell_q [ENTRIES];
    logic           qual_q [ENTRIES];
    wur_pkg::cell_t feed;
    logic           shift_en, clear_drawn;

    wur_pkg::cell_t head;
    logic           head_qual, ring_end, out_free, in_xfer;
    logic           start_xfer, draw_no_run, flush_no_run;

    assign head = cell_q[0];
    assign head_qual = qual_q[0];
    assign ring_end = (k_reg == CW'(ENTRIES - 1));
    assign out_free = !out_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;
    assign start_xfer = in_xfer && (s_payload.req_type == wur_pkg::REQ_START);
    assign draw_no_run = in_xfer && (s_payload.req_type == wur_pkg::REQ_DRAW) && !run_reg;
    assign flush_no_run = (state_reg == wur_pkg::ST_FLUSH)
                          && (hold_reg.error_code == wur_pkg::ERR_NO_RUN);

    generate
        for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
            wur_pkg::cell_t cin;
            if (i == ENTRIES - 1) begin : g_tail
                assign cin = feed;
            end else begin : g_mid
                assign cin = cell_q[i+1];
            end
            wur_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .shift_en    (shift_en),
                .clear_drawn (clear_drawn),
                .min_count   (min_reg),
                .cell_in     (cin),
                .cell_out    (cell_q[i]),
                .qual        (qual_q[i])
            );
        end
    endgenerate

    // configuration transfer, always taken
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= wur_pkg::TARGET_RESET;
            min_reg <= wur_pkg::MIN_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == wur_pkg::CFG_TARGET) begin
                target_reg <= cfg_data;
            end
            if (cfg_index == wur_pkg::CFG_MIN) begin
                min_reg <= cfg_data;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wur_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_payload.req_type == wur_pkg::REQ_LOAD) begin
                        state_next = wur_pkg::ST_LOAD;
                    end else if (s_payload.req_type == wur_pkg::REQ_START) begin
                        state_next = (target_reg == 32'd0) ? wur_pkg::ST_EVAL
                                                           : wur_pkg::ST_FLUSH;
                    end else if (s_payload.req_type == wur_pkg::REQ_DRAW && run_reg
                                 && pool_reg != 40'd0) begin
                        state_next = wur_pkg::ST_MUL;
                    end else begin
                        state_next = wur_pkg::ST_FLUSH;
                    end
                end
            end
            wur_pkg::ST_LOAD:   if (ring_end) state_next = wur_pkg::ST_FLUSH;
            wur_pkg::ST_MUL:    state_next = wur_pkg::ST_ADD;
            wur_pkg::ST_ADD:    state_next = wur_pkg::ST_WALK;
            wur_pkg::ST_WALK:   if (ring_end) state_next = wur_pkg::ST_DRAWN;
            wur_pkg::ST_DRAWN: begin
                state_next = (pending_next == 32'd0) ? wur_pkg::ST_EVAL
                                                     : wur_pkg::ST_FLUSH;
            end
            wur_pkg::ST_EVAL:   if (ring_end) state_next = wur_pkg::ST_DECIDE;
            wur_pkg::ST_DECIDE: begin
                state_next = ({6'd0, target_reg} <= total_reg) ? wur_pkg::ST_KEEP
                                                               : wur_pkg::ST_FLUSH;
            end
            wur_pkg::ST_KEEP: begin
                if (ring_end && shift_en) state_next = wur_pkg::ST_FLUSH;
            end
            wur_pkg::ST_FLUSH:  if (out_free) state_next = wur_pkg::ST_IDLE;
            default:            state_next = wur_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        k_next = k_reg;
        pool_next = pool_reg;
        pending_next = pending_reg;
        run_next = run_reg;
        item_next = item_reg;
        prod_lo_next = prod_lo_reg;
        prod_hi_next = prod_hi_reg;
        pick_next = pick_reg;
        found_next = found_reg;
        chosen_next = chosen_reg;
        total_next = total_reg;
        hold_next = hold_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        feed = head;
        shift_en = 1'b0;
        clear_drawn = 1'b0;
        s_ready = 1'b0;
        unique case (state_reg)
            wur_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                k_next = '0;
                found_next = 1'b0;
                chosen_next = '0;
                total_next = '0;
                if (s_valid) begin
                    item_next = s_payload;
                    hold_next = wur_pkg::make_result(wur_pkg::KIND_ACK, 5'd0, 32'd0,
                        32'd0, pending_reg, wur_pkg::ERR_NONE);
                    if (s_payload.req_type == wur_pkg::REQ_START) begin
                        clear_drawn = 1'b1;
                        pending_next = target_reg;
                        run_next = 1'b1;
                        hold_next.draws_pending = target_reg;
                    end else if (s_payload.req_type == wur_pkg::REQ_DRAW) begin
                        if (!run_reg) begin
                            hold_next = wur_pkg::make_result(wur_pkg::KIND_ERROR, 5'd0,
                                32'd0, 32'd0, pending_reg, wur_pkg::ERR_NO_RUN);
                        end else if (pool_reg == 40'd0) begin
                            hold_next = wur_pkg::make_result(wur_pkg::KIND_ERROR, 5'd0,
                                32'd0, 32'd0, pending_reg, wur_pkg::ERR_EMPTY);
                        end
                    end
                end
            end
            wur_pkg::ST_LOAD: begin
                shift_en = 1'b1;
                k_next = ring_end ? '0 : k_reg + 1'b1;
                if (XW'(k_reg) == XW'(item_reg.entry_index)) begin
                    feed = '{abund: item_reg.abundance, drawn: 32'd0,
                             feature: item_reg.feature_id};
                    pool_next = pool_reg - {8'd0, head.abund} + {8'd0, item_reg.abundance};
                end
            end
            wur_pkg::ST_MUL: begin
                // offset = r * pool / 2^32, split into two narrow products
                prod_lo_next = {32'd0, item_reg.random_fraction} * {32'd0, pool_reg[31:0]};
                prod_hi_next = {8'd0, item_reg.random_fraction} * {32'd0, pool_reg[39:32]};
            end
            wur_pkg::ST_ADD: begin
                pick_next = prod_hi_reg + {8'd0, prod_lo_reg[63:32]};
            end
            wur_pkg::ST_WALK: begin
                shift_en = 1'b1;
                k_next = ring_end ? '0 : k_reg + 1'b1;
                if (!found_reg) begin
                    if (pick_reg < {8'd0, head.abund}) begin
                        found_next = 1'b1;
                        chosen_next = k_reg;
                        feed.abund = head.abund - 32'd1;
                        feed.drawn = (head.drawn == 32'hFFFF_FFFF) ? head.drawn
                                                                  : head.drawn + 32'd1;
                        pool_next = pool_reg - 40'd1;
                    end else begin
                        pick_next = pick_reg - {8'd0, head.abund};
                    end
                end
            end
            wur_pkg::ST_DRAWN: begin
                pending_next = (pending_reg != 32'd0) ? pending_reg - 32'd1 : 32'd0;
                hold_next = wur_pkg::make_result(wur_pkg::KIND_DRAWN, 5'(chosen_reg),
                    32'd0, 32'd0, pending_next, wur_pkg::ERR_NONE);
            end
            wur_pkg::ST_EVAL: begin
                shift_en = 1'b1;
                k_next = ring_end ? '0 : k_reg + 1'b1;
                if (head_qual) begin
                    total_next = total_reg + {6'd0, head.drawn};
                end
            end
            wur_pkg::ST_DECIDE: begin
                if ({6'd0, target_reg} <= total_reg) begin
                    run_next = 1'b0;
                    pending_next = 32'd0;
                    hold_next.draws_pending = 32'd0;
                end else begin
                    pending_next = 32'(({6'd0, target_reg} - total_reg));
                    hold_next.draws_pending = pending_next;
                end
            end
            wur_pkg::ST_KEEP: begin
                // a kept slot stalls the ring until the held result can move on
                shift_en = !head_qual || out_free;
                if (shift_en) begin
                    k_next = ring_end ? '0 : k_reg + 1'b1;
                end
                if (head_qual && out_free) begin
                    out_next = hold_reg;
                    out_valid_next = 1'b1;
                    hold_next = wur_pkg::make_result(wur_pkg::KIND_KEPT, 5'(k_reg),
                        head.feature, head.drawn, 32'd0, wur_pkg::ERR_NONE);
                end
            end
            wur_pkg::ST_FLUSH: begin
                if (out_free) begin
                    out_next = hold_reg;
                    out_next.last = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                k_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wur_pkg::ST_IDLE;
            k_reg <= '0;
            pool_reg <= '0;
            pending_reg <= '0;
            run_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg <= k_next;
            pool_reg <= pool_next;
            pending_reg <= pending_next;
            run_reg <= run_next;
            out_valid_reg <= out_valid_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        pick_reg <= pick_next;
        chosen_reg <= chosen_next;
        total_reg <= total_next;
        hold_reg <= hold_next;
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_payload = out_reg;

    // the pool is a sum of at most ENTRIES 32-bit abundances
    `WUR_ASSERT(a_pool_range, aclk, aresetn, pool_reg[39:38] == 2'b00)
    // a draw with a nonempty pool always lands on a slot
    `WUR_ASSERT(a_walk_found, aclk, aresetn, state_reg == wur_pkg::ST_DRAWN |-> found_reg)
    // a start transfer arms the run
    `WUR_ASSERT(a_start_arms, aclk, aresetn, start_xfer |=> run_reg)
    // a draw with no run armed reports the error and nothing else
    `WUR_ASSERT(a_no_run_err, aclk, aresetn, draw_no_run |=> flush_no_run)
endmodule
